/* rtl/core/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int unsigned DefBookDepth = 32;
  localparam int unsigned MaxTrades    = 32;

  localparam int unsigned IdW     = 32;
  localparam int unsigned PriceW  = 16;
  localparam int unsigned UnitsW  = 20;
  localparam int unsigned BudgetW = 40;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StTrade     = 3'd0;
  localparam logic [StatusW-1:0] StInserted  = 3'd1;
  localparam logic [StatusW-1:0] StCancelled = 3'd2;
  localparam logic [StatusW-1:0] StNotFound  = 3'd3;
  localparam logic [StatusW-1:0] StRejected  = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpCancel = 1'b1;
  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_APPLY,
    S_BEST,
    S_BEST_LAST,
    S_READ,
    S_TRADE,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [PriceW-1:0]  price;
    logic [UnitsW-1:0]  units;
    logic [BudgetW-1:0] budget;
  } bid_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [UnitsW-1:0] units;
  } ask_t;

endpackage

/* rtl/core/limit_order_book_matcher_unit.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Two-sided order book with insert, cancel by id and repeated matching.
// ----------------------------------------------------------------------------
// Usage: drive operation_i/side_i/order_id_i/price_i/units_i/budget_i and
// pulse start_i while busy_o is low; the transaction is taken at that edge.
// busy_o drops in the cycle the final status result shows, so the next
// transaction can be taken at the edge that ends that result.
// Each result shows for one cycle with valid_o high; the receiver cannot
// stall, so results are never held. Every transaction ends with one status
// result carrying last_o; zero to MaxTrades trade results precede it.
// Book entries live in two synchronous memories (bid and ask, registered
// read). A scan over all BOOK_DEPTH entries of both tables reads one
// entry of each per cycle: the id search and free-slot search are one
// such scan, and each trade takes a best-price scan followed by read,
// update and write-back steps.
// Reset empties both tables at once (per-entry valid bits in flops); the
// memory contents need no clearing.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit
  import lobm_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = DefBookDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               operation_i,
  input  logic               side_i,
  input  logic [IdW-1:0]     order_id_i,
  input  logic [PriceW-1:0]  price_i,
  input  logic [UnitsW-1:0]  units_i,
  input  logic [BudgetW-1:0] budget_i,
  output logic               valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [IdW-1:0]     buy_order_id_o,
  output logic [IdW-1:0]     sell_order_id_o,
  output logic [UnitsW-1:0]  traded_units_o,
  output logic [PriceW-1:0]  bid_price_o,
  output logic [PriceW-1:0]  ask_price_o,
  output logic               last_o
);

  localparam int unsigned AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(BOOK_DEPTH - 1);
  localparam int unsigned TW = $clog2(MaxTrades + 1);

  // memories
  bid_t bid_mem [BOOK_DEPTH];
  ask_t ask_mem [BOOK_DEPTH];
  bid_t bid_rd_q;
  ask_t ask_rd_q;

  logic [BOOK_DEPTH-1:0] bid_vld_q, bid_vld_d, ask_vld_q, ask_vld_d;

  logic [AW-1:0] bid_raddr, ask_raddr;
  logic          bid_we, ask_we;
  logic [AW-1:0] bid_waddr, ask_waddr;
  bid_t          bid_wdata;
  ask_t          ask_wdata;

  always_ff @(posedge clk_i) begin
    if (bid_we) bid_mem[bid_waddr] <= bid_wdata;
    if (ask_we) ask_mem[ask_waddr] <= ask_wdata;
    bid_rd_q <= bid_mem[bid_raddr];
    ask_rd_q <= ask_mem[ask_raddr];
  end

  state_e state_q, state_d;

  // latched request
  logic               op_q, side_q;
  logic [IdW-1:0]     id_q;
  logic [PriceW-1:0]  price_q;
  logic [UnitsW-1:0]  units_q;
  logic [BudgetW-1:0] budget_q;
  logic [StatusW-1:0] status_q, status_d;

  // scan state
  logic [AW-1:0] cnt_q, cnt_d;   // address issued
  logic [AW-1:0] cmp_q, cmp_d;   // index of data in bid_rd_q/ask_rd_q
  logic          bid_hit_q, bid_hit_d, ask_hit_q, ask_hit_d;
  logic [AW-1:0] bid_hit_idx_q, bid_hit_idx_d, ask_hit_idx_q, ask_hit_idx_d;
  logic          free_f_q, free_f_d;
  logic [AW-1:0] free_idx_q, free_idx_d;

  // best search
  logic               bb_f_q, bb_f_d, ba_f_q, ba_f_d;
  logic [AW-1:0]      bb_idx_q, bb_idx_d, ba_idx_q, ba_idx_d;
  logic [PriceW-1:0]  bb_pr_q, bb_pr_d, ba_pr_q, ba_pr_d;
  logic [IdW-1:0]     bb_id_q, bb_id_d, ba_id_q, ba_id_d;

  // trade
  logic [UnitsW-1:0]          q_q, q_d;
  logic [UnitsW+PriceW-1:0]   cost_q, cost_d;
  logic [TW-1:0]              ntr_q, ntr_d;

  // output regs
  logic               valid_q, valid_d, last_q, last_d;
  logic [StatusW-1:0] ostat_q, ostat_d;
  logic [IdW-1:0]     obid_q, obid_d, osid_q, osid_d;
  logic [UnitsW-1:0]  otu_q, otu_d;
  logic [PriceW-1:0]  obp_q, obp_d, oap_q, oap_d;

  logic bid_ok, ask_ok;
  assign bid_ok = bid_vld_q[cmp_q];
  assign ask_ok = ask_vld_q[cmp_q];

  always_comb begin
    logic [UnitsW-1:0]  nbu, nau;
    logic [BudgetW-1:0] nbg, cost_w;
    nbu = '0; nau = '0; nbg = '0; cost_w = '0;
    state_d = state_q;
    cnt_d = cnt_q; cmp_d = cmp_q;
    bid_hit_d = bid_hit_q; bid_hit_idx_d = bid_hit_idx_q;
    ask_hit_d = ask_hit_q; ask_hit_idx_d = ask_hit_idx_q;
    free_f_d = free_f_q; free_idx_d = free_idx_q;
    bb_f_d = bb_f_q; bb_idx_d = bb_idx_q; bb_pr_d = bb_pr_q; bb_id_d = bb_id_q;
    ba_f_d = ba_f_q; ba_idx_d = ba_idx_q; ba_pr_d = ba_pr_q; ba_id_d = ba_id_q;
    q_d = q_q; cost_d = cost_q; ntr_d = ntr_q;
    status_d = status_q;
    bid_vld_d = bid_vld_q; ask_vld_d = ask_vld_q;
    bid_raddr = cnt_q; ask_raddr = cnt_q;
    bid_we = 1'b0; ask_we = 1'b0;
    bid_waddr = bb_idx_q; ask_waddr = ba_idx_q;
    bid_wdata = bid_rd_q; ask_wdata = ask_rd_q;
    valid_d = 1'b0; last_d = 1'b0;
    ostat_d = StTrade; obid_d = '0; osid_d = '0; otu_d = '0; obp_d = '0; oap_d = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          bid_hit_d = 1'b0; ask_hit_d = 1'b0; free_f_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN, S_SCAN_LAST, S_BEST, S_BEST_LAST: begin
        // address cnt_q issued this cycle; compare data of previous address
        if (state_q == S_SCAN || state_q == S_SCAN_LAST) begin
          if (state_q == S_SCAN_LAST || cnt_q != '0) begin
            if (bid_ok && bid_rd_q.id == id_q && !bid_hit_q) begin
              bid_hit_d = 1'b1; bid_hit_idx_d = cmp_q;
            end
            if (ask_ok && ask_rd_q.id == id_q && !ask_hit_q) begin
              ask_hit_d = 1'b1; ask_hit_idx_d = cmp_q;
            end
            if (!free_f_q && ((side_q == SideBuy) ? !bid_ok : !ask_ok)) begin
              free_f_d = 1'b1; free_idx_d = cmp_q;
            end
          end
        end else begin
          if (state_q == S_BEST_LAST || cnt_q != '0) begin
            if (bid_ok && (!bb_f_q || bid_rd_q.price > bb_pr_q ||
                (bid_rd_q.price == bb_pr_q && bid_rd_q.id > bb_id_q))) begin
              bb_f_d = 1'b1; bb_idx_d = cmp_q;
              bb_pr_d = bid_rd_q.price; bb_id_d = bid_rd_q.id;
            end
            if (ask_ok && (!ba_f_q || ask_rd_q.price < ba_pr_q ||
                (ask_rd_q.price == ba_pr_q && ask_rd_q.id < ba_id_q))) begin
              ba_f_d = 1'b1; ba_idx_d = cmp_q;
              ba_pr_d = ask_rd_q.price; ba_id_d = ask_rd_q.id;
            end
          end
        end
        cmp_d = cnt_q;
        if (state_q == S_SCAN) begin
          if (cnt_q == LastIdx) state_d = S_SCAN_LAST;
          else cnt_d = cnt_q + 1'b1;
        end else if (state_q == S_BEST) begin
          if (cnt_q == LastIdx) state_d = S_BEST_LAST;
          else cnt_d = cnt_q + 1'b1;
        end else if (state_q == S_SCAN_LAST) begin
          state_d = S_APPLY;
        end else begin
          // best search done
          if (bb_f_d && ba_f_d && bb_pr_d >= ba_pr_d && ntr_q != TW'(MaxTrades)) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_APPLY: begin
        if (op_q == OpInsert) begin
          if (bid_hit_q || ask_hit_q || !free_f_q) begin
            status_d = StRejected;
          end else if (side_q == SideBuy) begin
            bid_we = 1'b1; bid_waddr = free_idx_q;
            bid_wdata = '{id: id_q, price: price_q, units: units_q, budget: budget_q};
            bid_vld_d[free_idx_q] = 1'b1;
            status_d = StInserted;
          end else begin
            ask_we = 1'b1; ask_waddr = free_idx_q;
            ask_wdata = '{id: id_q, price: price_q, units: units_q};
            ask_vld_d[free_idx_q] = 1'b1;
            status_d = StInserted;
          end
        end else begin
          if (bid_hit_q) begin
            bid_vld_d[bid_hit_idx_q] = 1'b0; status_d = StCancelled;
          end else if (ask_hit_q) begin
            ask_vld_d[ask_hit_idx_q] = 1'b0; status_d = StCancelled;
          end else begin
            status_d = StNotFound;
          end
        end
        ntr_d = '0;
        cnt_d = '0; bb_f_d = 1'b0; ba_f_d = 1'b0;
        state_d = S_BEST;
      end
      S_READ: begin
        bid_raddr = bb_idx_q; ask_raddr = ba_idx_q;
        state_d = S_TRADE;
      end
      S_TRADE: begin
        // keep the best entries on the read ports for the write-back cycle
        bid_raddr = bb_idx_q; ask_raddr = ba_idx_q;
        q_d = (bid_rd_q.units < ask_rd_q.units) ? bid_rd_q.units : ask_rd_q.units;
        cost_d = q_d * bid_rd_q.price;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cost_w = BudgetW'(cost_q);
        nbu = bid_rd_q.units - q_q;
        nau = ask_rd_q.units - q_q;
        nbg = (bid_rd_q.budget > cost_w) ? bid_rd_q.budget - cost_w : '0;
        bid_we = 1'b1; ask_we = 1'b1;
        bid_wdata.units = nbu; bid_wdata.budget = nbg;
        ask_wdata.units = nau;
        if (nbu == '0 || nbg == '0) bid_vld_d[bb_idx_q] = 1'b0;
        if (nau == '0) ask_vld_d[ba_idx_q] = 1'b0;
        valid_d = 1'b1; ostat_d = StTrade;
        obid_d = bid_rd_q.id; osid_d = ask_rd_q.id; otu_d = q_q;
        obp_d = bid_rd_q.price; oap_d = ask_rd_q.price;
        ntr_d = ntr_q + 1'b1;
        cnt_d = '0; bb_f_d = 1'b0; ba_f_d = 1'b0;
        state_d = S_BEST;
      end
      S_DONE: begin
        valid_d = 1'b1; last_d = 1'b1; ostat_d = status_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bid_vld_q <= '0;
      ask_vld_q <= '0;
      valid_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bid_vld_q <= bid_vld_d;
      ask_vld_q <= ask_vld_d;
      valid_q <= valid_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q <= operation_i; side_q <= side_i; id_q <= order_id_i;
      price_q <= price_i; units_q <= units_i; budget_q <= budget_i;
    end
    cnt_q <= cnt_d; cmp_q <= cmp_d;
    bid_hit_q <= bid_hit_d; bid_hit_idx_q <= bid_hit_idx_d;
    ask_hit_q <= ask_hit_d; ask_hit_idx_q <= ask_hit_idx_d;
    free_f_q <= free_f_d; free_idx_q <= free_idx_d;
    bb_f_q <= bb_f_d; bb_idx_q <= bb_idx_d; bb_pr_q <= bb_pr_d; bb_id_q <= bb_id_d;
    ba_f_q <= ba_f_d; ba_idx_q <= ba_idx_d; ba_pr_q <= ba_pr_d; ba_id_q <= ba_id_d;
    q_q <= q_d; cost_q <= cost_d; ntr_q <= ntr_d;
    status_q <= status_d;
    ostat_q <= ostat_d; obid_q <= obid_d; osid_q <= osid_d;
    otu_q <= otu_d; obp_q <= obp_d; oap_q <= oap_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = valid_q;
  assign last_o          = last_q;
  assign status_o        = ostat_q;
  assign buy_order_id_o  = obid_q;
  assign sell_order_id_o = osid_q;
  assign traded_units_o  = otu_q;
  assign bid_price_o     = obp_q;
  assign ask_price_o     = oap_q;

`ifndef NO_ASSERTIONS
  // a trade result never carries last
  a_trade_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StTrade |-> !last_o)
    else $error("trade result marked last");
  // a trade only happens on a crossed book
  a_trade_crossed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> bid_price_o >= ask_price_o)
    else $error("trade on uncrossed book");
  // last result returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("busy after last result");
  // trade count stays within the cap
  a_trade_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ntr_q <= TW'(MaxTrades) || state_q == S_IDLE || state_q == S_SCAN ||
    state_q == S_SCAN_LAST || state_q == S_APPLY)
    else $error("trade cap exceeded");
`endif

endmodule

/* test/limit_order_book_matcher_unit_tb.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit_tb
// Drives inserts and cancels into the order book matcher and checks every
// trade and status result against a cycle-free model of the book.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit_tb;
  import lobm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DefBookDepth;

  typedef struct packed {
    logic               op;
    logic               side;
    logic [IdW-1:0]     id;
    logic [PriceW-1:0]  price;
    logic [UnitsW-1:0]  units;
    logic [BudgetW-1:0] budget;
  } order_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     buy_id;
    logic [IdW-1:0]     sell_id;
    logic [UnitsW-1:0]  units;
    logic [PriceW-1:0]  bid_price;
    logic [PriceW-1:0]  ask_price;
    logic               last;
  } fill_t;

  // directed row: has_st means the final status is typed in here
  typedef struct packed {
    order_t             ord;
    logic               has_st;
    logic [StatusW-1:0] st;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               operation_i = 1'b0;
  logic               side_i = 1'b0;
  logic [IdW-1:0]     order_id_i = '0;
  logic [PriceW-1:0]  price_i = '0;
  logic [UnitsW-1:0]  units_i = '0;
  logic [BudgetW-1:0] budget_i = '0;
  logic               valid_o;
  logic [StatusW-1:0] status_o;
  logic [IdW-1:0]     buy_order_id_o;
  logic [IdW-1:0]     sell_order_id_o;
  logic [UnitsW-1:0]  traded_units_o;
  logic [PriceW-1:0]  bid_price_o;
  logic [PriceW-1:0]  ask_price_o;
  logic               last_o;

  limit_order_book_matcher_unit u_top (.*);

  always #6 clk_i = ~clk_i;

  // book copy
  bit                 bids_live[Depth];
  logic [IdW-1:0]     bids_id[Depth];
  logic [PriceW-1:0]  bids_price[Depth];
  logic [UnitsW-1:0]  bids_units[Depth];
  logic [BudgetW-1:0] bids_budget[Depth];
  bit                 asks_live[Depth];
  logic [IdW-1:0]     asks_id[Depth];
  logic [PriceW-1:0]  asks_price[Depth];
  logic [UnitsW-1:0]  asks_units[Depth];

  fill_t pending_fills[$];
  int    errors = 0;

  function automatic int find_bid(logic [IdW-1:0] id);
    for (int i = 0; i < Depth; i++) if (bids_live[i] && bids_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_ask(logic [IdW-1:0] id);
    for (int i = 0; i < Depth; i++) if (asks_live[i] && asks_id[i] == id) return i;
    return -1;
  endfunction

  task automatic book_order(order_t o, logic has_st, logic [StatusW-1:0] typed_st);
    logic [StatusW-1:0] st;
    int s, b, a;
    logic [UnitsW-1:0] q;
    logic [BudgetW+PriceW:0] cost;
    fill_t f;
    s = -1;
    if (o.op == OpInsert) begin
      if (find_bid(o.id) >= 0 || find_ask(o.id) >= 0) begin
        st = StRejected;
      end else if (o.side == SideBuy) begin
        for (int i = Depth - 1; i >= 0; i--) if (!bids_live[i]) s = i;
        if (s < 0) begin
          st = StRejected;
        end else begin
          bids_live[s] = 1; bids_id[s] = o.id; bids_price[s] = o.price;
          bids_units[s] = o.units; bids_budget[s] = o.budget;
          st = StInserted;
        end
      end else begin
        for (int i = Depth - 1; i >= 0; i--) if (!asks_live[i]) s = i;
        if (s < 0) begin
          st = StRejected;
        end else begin
          asks_live[s] = 1; asks_id[s] = o.id; asks_price[s] = o.price;
          asks_units[s] = o.units;
          st = StInserted;
        end
      end
    end else begin
      s = find_bid(o.id);
      if (s >= 0) begin
        bids_live[s] = 0; st = StCancelled;
      end else begin
        s = find_ask(o.id);
        if (s >= 0) begin
          asks_live[s] = 0; st = StCancelled;
        end else begin
          st = StNotFound;
        end
      end
    end
    for (int t = 0; t < MaxTrades; t++) begin
      b = -1; a = -1;
      for (int i = 0; i < Depth; i++) begin
        if (bids_live[i] && (b < 0 || bids_price[i] > bids_price[b] ||
            (bids_price[i] == bids_price[b] && bids_id[i] > bids_id[b]))) b = i;
        if (asks_live[i] && (a < 0 || asks_price[i] < asks_price[a] ||
            (asks_price[i] == asks_price[a] && asks_id[i] < asks_id[a]))) a = i;
      end
      if (b < 0 || a < 0 || bids_price[b] < asks_price[a]) break;
      q = (bids_units[b] < asks_units[a]) ? bids_units[b] : asks_units[a];
      cost = q * bids_price[b];
      bids_units[b] -= q;
      asks_units[a] -= q;
      bids_budget[b] = (bids_budget[b] > cost) ? bids_budget[b] - cost : '0;
      f = '{StTrade, bids_id[b], asks_id[a], q, bids_price[b], asks_price[a], 1'b0};
      pending_fills.push_back(f);
      if (bids_units[b] == 0 || bids_budget[b] == 0) bids_live[b] = 0;
      if (asks_units[a] == 0) asks_live[a] = 0;
    end
    f = '{has_st ? typed_st : st, '0, '0, '0, '0, '0, 1'b1};
    pending_fills.push_back(f);
  endtask

  // caller stands at a falling edge; returns at the falling edge after acceptance
  task automatic send(order_t o, logic has_st = 1'b0, logic [StatusW-1:0] st = '0);
    operation_i = o.op; side_i = o.side; order_id_i = o.id;
    price_i = o.price; units_i = o.units; budget_i = o.budget;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    book_order(o, has_st, st);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int pct);
    while ($urandom_range(99) < pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic order_t rand_order();
    order_t o;
    int r;
    r = $urandom_range(99);
    o.op = (r >= 80) ? OpCancel : OpInsert;
    o.side = (r < 45) ? SideBuy : SideSell;
    if (o.op == OpCancel) o.side = 1'($urandom_range(1));
    o.id = ($urandom_range(9) == 0) ? IdW'($urandom) : IdW'($urandom_range(1, 60));
    r = $urandom_range(99);
    if (r < 70) o.price = PriceW'($urandom_range(980, 1020));
    else if (r < 85) o.price = PriceW'($urandom);
    else o.price = $urandom_range(1) ? '1 : '0;
    r = $urandom_range(99);
    if (r < 80) o.units = UnitsW'($urandom_range(1, 50));
    else if (r < 90) o.units = UnitsW'($urandom);
    else o.units = $urandom_range(1) ? '1 : '0;
    r = $urandom_range(99);
    if (r < 70) o.budget = BudgetW'({$urandom, $urandom});
    else if (r < 90) o.budget = BudgetW'($urandom_range(5000));
    else o.budget = '0;
    return o;
  endfunction

  always @(posedge clk_i) begin
    fill_t got, want;
    if (rst_ni && valid_o) begin
      got = '{status_o, buy_order_id_o, sell_order_id_o, traded_units_o,
              bid_price_o, ask_price_o, last_o};
      if (pending_fills.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = pending_fills.pop_front();
        if (got.status !== want.status || got.buy_id !== want.buy_id ||
            got.sell_id !== want.sell_id || got.units !== want.units ||
            got.bid_price !== want.bid_price || got.ask_price !== want.ask_price ||
            got.last !== want.last) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t  rows[$];
    order_t o;
    int    pct;
    rows = '{
      '{'{OpCancel, SideBuy, 32'd0, 16'd0, 20'd0, 40'd0}, 1'b1, StNotFound},
      '{'{OpInsert, SideBuy, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 40'hFF_FFFF_FFFF},
        1'b1, StInserted},
      '{'{OpInsert, SideBuy, 32'd5, 16'd100, 20'd10, 40'd1000}, 1'b1, StInserted},
      '{'{OpInsert, SideSell, 32'd5, 16'd1, 20'd1, 40'd0}, 1'b1, StRejected},
      '{'{OpInsert, SideSell, 32'd0, 16'd0, 20'd1, 40'd0}, 1'b0, StTrade},
      '{'{OpCancel, SideSell, 32'hFFFF_FFFF, 16'd0, 20'd0, 40'd0}, 1'b1, StCancelled},
      '{'{OpInsert, SideSell, 32'd7, 16'd100, 20'd3, 40'd0}, 1'b0, StTrade},
      '{'{OpInsert, SideSell, 32'd9, 16'd200, 20'd5, 40'd0}, 1'b0, StTrade},
      '{'{OpInsert, SideSell, 32'd8, 16'd200, 20'd5, 40'd0}, 1'b0, StTrade},
      '{'{OpInsert, SideBuy, 32'd10, 16'd200, 20'd20, 40'd5000}, 1'b0, StTrade},
      '{'{OpInsert, SideSell, 32'd14, 16'd250, 20'd50, 40'd0}, 1'b0, StTrade},
      '{'{OpInsert, SideBuy, 32'd11, 16'd300, 20'd0, 40'd100}, 1'b0, StTrade},
      '{'{OpInsert, SideBuy, 32'd12, 16'd300, 20'd5, 40'd0}, 1'b0, StTrade},
      '{'{OpInsert, SideBuy, 32'd13, 16'd250, 20'd100, 40'd1}, 1'b0, StTrade},
      '{'{OpInsert, SideSell, 32'd20, 16'd60000, 20'd1, 40'd0}, 1'b0, StTrade},
      '{'{OpCancel, SideBuy, 32'd20, 16'd0, 20'd0, 40'd0}, 1'b1, StCancelled},
      '{'{OpCancel, SideSell, 32'd20, 16'd0, 20'd0, 40'd0}, 1'b1, StNotFound},
      '{'{OpInsert, SideBuy, 32'd30, 16'd50, 20'd2, 40'd1000}, 1'b0, StTrade},
      '{'{OpInsert, SideBuy, 32'd31, 16'd50, 20'd2, 40'd1000}, 1'b0, StTrade},
      '{'{OpInsert, SideSell, 32'd32, 16'd40, 20'd3, 40'd0}, 1'b0, StTrade}
    };
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send(rows[i].ord, rows[i].has_st, rows[i].st);

    for (int n = 0; n < 104; n++) begin
      case (n / 26)
        0: pct = 0;
        1: pct = 79;
        2: pct = 0;
        default: pct = 23;
      endcase
      if (n == 52) begin
        // flood the ask table at the top price, then sweep it up to the trade cap
        for (int k = 0; k < Depth + 2; k++) begin
          o = '{OpInsert, SideSell, 32'h8000_0000 + k, 16'hFFFF, 20'd1, 40'd0};
          send(o);
        end
        o = '{OpInsert, SideBuy, 32'h9000_0000, 16'hFFFF, 20'hFFFFF, 40'hFF_FFFF_FFFF};
        send(o);
        o = '{OpCancel, SideBuy, 32'h9000_0000, 16'd0, 20'd0, 40'd0};
        send(o);
      end
      idle_cycles(pct);
      send(rand_order());
    end
    start_i = 1'b0;

    while (pending_fills.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
